// File: rtl/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;
  localparam int unsigned PageCount  = 1024;
  localparam int unsigned OrderCount = 11;
  localparam int unsigned PageW      = 10;
  localparam int unsigned LinkW      = 11;
  localparam int unsigned OrderW     = 4;
  localparam int unsigned TotalW     = 11;
  localparam logic [LinkW-1:0] Nil   = LinkW'(PageCount);
  localparam logic [TotalW-1:0] TotalMax = 11'd2047;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StWmark  = 2'd1;
  localparam logic [1:0] StNoBlk  = 2'd2;
  localparam logic [1:0] StBadFree = 2'd3;

  localparam logic [1:0] RegZone    = 2'd0;
  localparam logic [1:0] RegLowMark = 2'd1;
  localparam logic [1:0] RegReserve = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_WM_STEP, S_SEARCH, S_TAKE_RD, S_UNLINK_A, S_UNLINK_B,
    S_SPLIT, S_PUSH_CHK, S_PUSH_RD, S_PUSH_UNL_A, S_PUSH_UNL_B, S_PUSH_WR,
    S_FREE_CHK, S_FREE_RD, S_FREE_TEST, S_RESULT
  } state_e;

  // Datapath command per cycle.
  typedef struct packed {
    logic clr_step;      // clear one free-head flag after reset
    logic load_item;     // capture input item
    logic wm_init;       // start watermark check
    logic wm_step;       // one order of the watermark loop
    logic search_step;   // advance list search
    logic rd_meta;       // issue metadata read of cur page, tgt or buddy
    logic unlink_a;      // fix predecessor / list head
    logic unlink_b;      // fix successor, clear head flag, count down
    logic take_head;     // cur page := list head of search order
    logic sub_total;     // subtract allocation size
    logic split_step;    // k--, tgt := page + 2^k
    logic sel_tgt;       // metadata address := tgt
    logic push_wr;       // push tgt on list k, or the freed block on its order list
    logic add_total;     // add freed size
    logic merge_step;    // unlink buddy, widen block
    logic sel_buddy;     // metadata address := buddy
    logic set_status;
    logic [1:0] status;
    logic out_load;
  } bpa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_free;
    logic order_bad;
    logic wm_fail;
    logic wm_done;
    logic list_found;
    logic search_end;
    logic split_done;
    logic tgt_in_range;
    logic tgt_is_head;
    logic free_bad;
    logic can_merge_idx;
    logic buddy_merge;
  } bpa_sts_t;
endpackage
`default_nettype wire

// File: rtl/bpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bpa_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire bpa_pkg::bpa_sts_t sts_i,
  output bpa_pkg::bpa_cmd_t    cmd_o
);
  import bpa_pkg::*;
  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    ov_d       = ov_q && !out_ready_i;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.op_free) begin
          cmd_o.rd_meta = 1'b1;
          state_d = S_FREE_CHK;
        end else if (sts_i.order_bad) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = StNoBlk;
          state_d = S_RESULT;
        end else begin
          cmd_o.wm_init = 1'b1;
          state_d = S_WM_STEP;
        end
      end
      S_WM_STEP: begin
        if (sts_i.wm_fail) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = StWmark;
          state_d = S_RESULT;
        end else if (sts_i.wm_done) begin
          state_d = S_SEARCH;
        end else begin
          cmd_o.wm_step = 1'b1;
        end
      end
      S_SEARCH: begin
        if (sts_i.search_end) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = StNoBlk;
          state_d = S_RESULT;
        end else if (sts_i.list_found) begin
          cmd_o.take_head = 1'b1;
          state_d = S_TAKE_RD;
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      S_TAKE_RD: begin
        cmd_o.rd_meta = 1'b1;
        state_d = S_UNLINK_A;
      end
      S_UNLINK_A: begin
        cmd_o.unlink_a = 1'b1;
        state_d = S_UNLINK_B;
      end
      S_UNLINK_B: begin
        cmd_o.unlink_b = 1'b1;
        cmd_o.sub_total = 1'b1;
        state_d = S_SPLIT;
      end
      S_SPLIT: begin
        if (sts_i.split_done) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = StOk;
          state_d = S_RESULT;
        end else begin
          cmd_o.split_step = 1'b1;
          state_d = S_PUSH_CHK;
        end
      end
      S_PUSH_CHK: begin
        cmd_o.sel_tgt = 1'b1;
        if (!sts_i.tgt_in_range) begin
          state_d = S_SPLIT;
        end else begin
          cmd_o.rd_meta = 1'b1;
          state_d = S_PUSH_RD;
        end
      end
      S_PUSH_RD: begin
        if (sts_i.tgt_is_head) begin
          state_d = S_PUSH_UNL_A;
        end else begin
          state_d = S_PUSH_WR;
        end
      end
      S_PUSH_UNL_A: begin
        cmd_o.unlink_a = 1'b1;
        state_d = S_PUSH_UNL_B;
      end
      S_PUSH_UNL_B: begin
        cmd_o.unlink_b = 1'b1;
        state_d = S_PUSH_WR;
      end
      S_PUSH_WR: begin
        cmd_o.push_wr = 1'b1;
        state_d = sts_i.op_free ? S_RESULT : S_SPLIT;
        if (sts_i.op_free) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = StOk;
        end
      end
      S_FREE_CHK: begin
        if (sts_i.free_bad) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = StBadFree;
          state_d = S_RESULT;
        end else begin
          cmd_o.add_total = 1'b1;
          state_d = S_FREE_RD;
        end
      end
      S_FREE_RD: begin
        cmd_o.sel_buddy = 1'b1;
        if (sts_i.can_merge_idx) begin
          cmd_o.rd_meta = 1'b1;
          state_d = S_FREE_TEST;
        end else begin
          state_d = S_PUSH_WR;
        end
      end
      S_FREE_TEST: begin
        if (sts_i.buddy_merge) begin
          cmd_o.unlink_a = 1'b1;
          cmd_o.merge_step = 1'b1;
          state_d = S_FREE_RD;
        end else begin
          state_d = S_PUSH_WR;
        end
      end
      S_RESULT: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/bpa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module bpa_datapath (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire bpa_pkg::bpa_cmd_t        cmd_i,
  output bpa_pkg::bpa_sts_t             sts_o,
  input  wire logic                     in_op_i,
  input  wire logic [bpa_pkg::OrderW-1:0] in_order_i,
  input  wire logic [bpa_pkg::PageW-1:0]  in_page_i,
  input  wire logic [bpa_pkg::TotalW-1:0] zone_pages_i,
  input  wire logic [bpa_pkg::TotalW-1:0] low_mark_i,
  input  wire logic [bpa_pkg::TotalW-1:0] reserve_i,
  output logic [1:0]                    status_o,
  output logic [bpa_pkg::PageW-1:0]     rpage_o,
  output logic [bpa_pkg::OrderW-1:0]    rorder_o,
  output logic [bpa_pkg::TotalW-1:0]    total_o
);
  import bpa_pkg::*;

  // Metadata memories: registered read.
  logic [OrderW-1:0] ord_mem [PageCount];
  logic [LinkW-1:0]  nxt_mem [PageCount];
  logic [LinkW-1:0]  prv_mem [PageCount];
  logic              flg_mem [PageCount];  // free-head flags, cleared by a pass after reset

  logic [LinkW-1:0]  first_q [OrderCount];
  logic [LinkW-1:0]  cnt_q   [OrderCount];
  logic [TotalW-1:0] total_q;
  logic [PageW-1:0]  clr_q;

  logic              op_q;
  logic [OrderW-1:0] ord_q;   // requested / current merge order
  logic [PageW-1:0]  page_q;  // current block page
  logic [OrderW-1:0] k_q;     // search / split order
  logic [LinkW-1:0]  tgt_q;   // push target
  logic [OrderW-1:0] rd_ord_q;
  logic [LinkW-1:0]  rd_nxt_q, rd_prv_q;
  logic              rd_flg_q;
  logic [PageW-1:0]  rd_addr_q;
  logic signed [13:0] wf_q, wm_q;
  logic [OrderW-1:0] wo_q;
  logic              wfail_q;
  logic [1:0]        stat_q;
  logic [PageW-1:0]  maddr;
  logic [PageW-1:0]  buddy;
  logic [LinkW-1:0]  limit;
  logic [11:0]       sz;
  logic [3:0]        ko;
  logic [11:0]       tsum;

  assign limit = (zone_pages_i > TotalW'(PageCount)) ? LinkW'(PageCount) : zone_pages_i;
  assign sz    = 12'd1 << ord_q;
  assign buddy = page_q ^ PageW'(sz[PageW-1:0]);
  assign ko    = 4'((rd_ord_q >= OrderW'(OrderCount)) ? rd_ord_q - OrderW'(OrderCount)
                    : rd_ord_q);
  assign tsum  = {1'b0, total_q} + sz;

  always_comb begin
    maddr = page_q;
    if (cmd_i.sel_tgt) maddr = tgt_q[PageW-1:0];
    if (cmd_i.sel_buddy) maddr = buddy;
  end

  always_comb begin
    sts_o = '0;
    sts_o.clr_last    = clr_q == PageW'(PageCount - 1);
    sts_o.op_free     = op_q;
    sts_o.order_bad   = ord_q >= OrderW'(OrderCount);
    sts_o.wm_fail     = wfail_q;
    sts_o.wm_done     = wo_q == ord_q;
    sts_o.list_found  = first_q[k_q] < Nil;
    sts_o.search_end  = k_q >= OrderW'(OrderCount);
    sts_o.split_done  = k_q == ord_q;
    sts_o.tgt_in_range = tgt_q < Nil;
    sts_o.tgt_is_head = rd_flg_q;
    sts_o.free_bad    = (ord_q >= OrderW'(OrderCount)) ||
                        ((page_q & PageW'(sz - 12'd1)) != '0) ||
                        ({1'b0, page_q} >= limit) ||
                        (sz > 12'(limit - {1'b0, page_q})) ||
                        rd_flg_q;
    sts_o.can_merge_idx = (ord_q < OrderW'(OrderCount - 1)) &&
                          ({1'b0, buddy} < limit);
    sts_o.buddy_merge = rd_flg_q && (rd_ord_q == ord_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_meta) begin
      rd_ord_q  <= ord_mem[maddr];
      rd_nxt_q  <= nxt_mem[maddr];
      rd_prv_q  <= prv_mem[maddr];
      rd_flg_q  <= flg_mem[maddr];
      rd_addr_q <= maddr;
    end
    if (cmd_i.clr_step) flg_mem[clr_q] <= 1'b0;
    if (cmd_i.unlink_a && rd_prv_q < Nil) nxt_mem[rd_prv_q[PageW-1:0]] <= rd_nxt_q;
    if (cmd_i.unlink_b && rd_nxt_q < Nil) prv_mem[rd_nxt_q[PageW-1:0]] <= rd_prv_q;
    if (cmd_i.unlink_b || cmd_i.merge_step) flg_mem[rd_addr_q] <= 1'b0;
    // buddy unlink: fix successor, drop its flag and count in the same cycle
    if (cmd_i.merge_step && rd_nxt_q < Nil) prv_mem[rd_nxt_q[PageW-1:0]] <= rd_prv_q;
    if (cmd_i.push_wr) begin
      if (op_q) begin
        nxt_mem[page_q] <= first_q[ord_q];
        prv_mem[page_q] <= Nil;
        ord_mem[page_q] <= ord_q;
        flg_mem[page_q] <= 1'b1;
        if (first_q[ord_q] < Nil) prv_mem[first_q[ord_q][PageW-1:0]] <= {1'b0, page_q};
      end else begin
        nxt_mem[tgt_q[PageW-1:0]] <= first_q[k_q];
        prv_mem[tgt_q[PageW-1:0]] <= Nil;
        ord_mem[tgt_q[PageW-1:0]] <= k_q;
        flg_mem[tgt_q[PageW-1:0]] <= 1'b1;
        if (first_q[k_q] < Nil) prv_mem[first_q[k_q][PageW-1:0]] <= tgt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      total_q <= '0;
      for (int i = 0; i < OrderCount; i++) begin
        first_q[i] <= Nil;
        cnt_q[i]   <= '0;
      end
      wfail_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.wm_init) begin
        wfail_q <= ($signed({3'b0, total_q}) - $signed({2'b0, sz}) + 14'sd1) <=
                   ($signed({3'b0, low_mark_i}) + $signed({3'b0, reserve_i}));
      end else if (cmd_i.wm_step) begin
        wfail_q <= (wf_q - $signed({1'b0, 13'(cnt_q[wo_q] << wo_q)})) <= (wm_q >>> 1);
      end
      if (cmd_i.unlink_a && rd_prv_q >= Nil) first_q[ko] <= rd_nxt_q;
      if (cmd_i.unlink_b) begin
        if (cnt_q[ko] != '0) cnt_q[ko] <= cnt_q[ko] - 1'b1;
      end
      if (cmd_i.sub_total) total_q <= (total_q >= TotalW'(sz)) ? total_q - TotalW'(sz) : '0;
      if (cmd_i.add_total) total_q <= tsum > 12'(TotalMax) ? TotalMax : tsum[TotalW-1:0];
      if (cmd_i.push_wr) begin
        if (op_q) begin
          first_q[ord_q] <= {1'b0, page_q};
          cnt_q[ord_q]   <= cnt_q[ord_q] + 1'b1;
        end else begin
          first_q[k_q] <= tgt_q;
          cnt_q[k_q]   <= cnt_q[k_q] + 1'b1;
        end
      end
      if (cmd_i.merge_step) begin
        if (cnt_q[ko] != '0) cnt_q[ko] <= cnt_q[ko] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= in_op_i;
      ord_q  <= in_order_i;
      page_q <= in_page_i;
      k_q    <= in_order_i;
      wo_q   <= '0;
    end
    if (cmd_i.wm_init) begin
      wf_q <= $signed({3'b0, total_q}) - $signed({2'b0, sz}) + 14'sd1;
      wm_q <= $signed({3'b0, low_mark_i});
    end
    if (cmd_i.wm_step) begin
      wf_q <= wf_q - $signed({1'b0, 13'(cnt_q[wo_q] << wo_q)});
      wm_q <= wm_q >>> 1;
      wo_q <= wo_q + 1'b1;
    end
    if (cmd_i.search_step) k_q <= k_q + 1'b1;
    if (cmd_i.take_head) page_q <= first_q[k_q][PageW-1:0];
    if (cmd_i.split_step) begin
      k_q   <= k_q - 1'b1;
      tgt_q <= {1'b0, page_q} + LinkW'(12'd1 << (k_q - 1'b1));
    end
    if (cmd_i.merge_step) begin
      page_q <= page_q & ~PageW'(sz[PageW-1:0]);
      ord_q  <= ord_q + 1'b1;
    end
    if (cmd_i.set_status) stat_q <= cmd_i.status;
    if (cmd_i.out_load) begin
      status_o <= stat_q;
      rpage_o  <= (stat_q == StOk) ? page_q : '0;
      rorder_o <= (stat_q == StOk) ? ord_q : '0;
      total_o  <= total_q;
    end
  end
endmodule
`default_nettype wire

// File: rtl/buddy_page_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Transaction
// s_axis    in   tdata {page_index, block_order, operation}
// m_axis    out  tdata {free_pages_now, result_order, result_page, status}
// apb       in   zone_pages @0, low_watermark @4, reserve_pages @8
// Flow: one transaction at a time. An allocate checks the watermark order by order,
//   searches upward for a non-empty list, unlinks its head and splits down, pushing each
//   upper half that lies inside the page range (unlinking it first when it is already a
//   list head); a refused or bad-order allocate ends sooner. Free checks the block, merges
//   with its buddy while it can and pushes the result; a bad free ends sooner.
// Reset clears list heads, counts and the total; a pass over all pages then clears the
//   free-head flags with s_axis_tready held low.
// A waiting result holds m_axis; a new transaction waits for it before its result loads.
module buddy_page_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [0] operation, [4:1] block_order, [14:5] page_index
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [1:0] status, [11:2] result_page,
                                          // [15:12] result_order, [26:16] free_pages_now
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bpa_pkg::*;
  bpa_cmd_t cmd;
  bpa_sts_t sts;
  logic [TotalW-1:0] zone_q, low_q, res_q;
  logic [1:0] st;
  logic [PageW-1:0] rp;
  logic [OrderW-1:0] ro;
  logic [TotalW-1:0] tot;

  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= TotalW'(PageCount);
      low_q  <= '0;
      res_q  <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegZone:    zone_q <= pwdata[TotalW-1:0];
        RegLowMark: low_q  <= pwdata[TotalW-1:0];
        RegReserve: res_q  <= pwdata[TotalW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegZone:    prdata = {21'b0, zone_q};
      RegLowMark: prdata = {21'b0, low_q};
      RegReserve: prdata = {21'b0, res_q};
      default:    prdata = '0;
    endcase
  end

  bpa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpa_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_op_i     (s_axis_tdata[0]),
    .in_order_i  (s_axis_tdata[4:1]),
    .in_page_i   (s_axis_tdata[14:5]),
    .zone_pages_i(zone_q),
    .low_mark_i  (low_q),
    .reserve_i   (res_q),
    .status_o    (st),
    .rpage_o     (rp),
    .rorder_o    (ro),
    .total_o     (tot)
  );

  assign m_axis_tdata = {5'b0, tot, ro, rp, st};
endmodule
`default_nettype wire

// File: bench/buddy_page_allocator_test.sv
`timescale 1ns / 1ps
module buddy_page_allocator_test;
  import bpa_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  page;
    logic [3:0]  order;
    logic [10:0] free_now;
  } alloc_result_t;

  // Shadow buddy allocator: predicts one result per accepted transaction.
  class buddy_scoreboard;
    bit          head_flag[PageCount];
    bit [3:0]    head_ord[PageCount];
    int unsigned nxt[PageCount];
    int unsigned prv[PageCount];
    int unsigned first_blk[OrderCount];
    int unsigned blk_cnt[OrderCount];
    int unsigned total;
    int unsigned zone, low_mark, reserve;
    alloc_result_t pending_q[$];
    int unsigned errors;

    function new();
      for (int k = 0; k < OrderCount; k++) begin
        first_blk[k] = PageCount;
        blk_cnt[k] = 0;
      end
      total = 0;
      zone = PageCount;
      low_mark = 0;
      reserve = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, int unsigned val);
      if (idx == RegZone) zone = val & 'h7FF;
      else if (idx == RegLowMark) low_mark = val & 'h7FF;
      else if (idx == RegReserve) reserve = val & 'h7FF;
    endfunction

    function void drop_head(int unsigned p);
      int unsigned k, n, b;
      k = head_ord[p] % OrderCount;
      n = nxt[p];
      b = prv[p];
      if (b < PageCount) nxt[b] = n;
      else first_blk[k] = n;
      if (n < PageCount) prv[n] = b;
      head_flag[p] = 0;
      if (blk_cnt[k] > 0) blk_cnt[k]--;
    endfunction

    function void add_head(int unsigned p, int unsigned k);
      int unsigned f;
      f = first_blk[k];
      if (head_flag[p]) drop_head(p);
      nxt[p] = f;
      prv[p] = PageCount;
      if (f < PageCount) prv[f] = p;
      first_blk[k] = p;
      head_ord[p] = 4'(k);
      head_flag[p] = 1;
      blk_cnt[k]++;
    endfunction

    function bit mark_clear(int unsigned ord);
      longint f, m;
      f = longint'(total) - (longint'(1) << ord) + 1;
      m = low_mark;
      if (f <= m + longint'(reserve)) return 0;
      for (int o = 0; o < ord; o++) begin
        f -= longint'(blk_cnt[o]) << o;
        m = m >>> 1;
        if (f <= m) return 0;
      end
      return 1;
    endfunction

    // Note one accepted transaction and queue the predicted result.
    function alloc_result_t note_request(logic op, logic [3:0] ord_in, logic [9:0] pg_in);
      alloc_result_t r;
      int unsigned ord, page, lim, k, p, sz;
      ord = ord_in;
      page = pg_in;
      lim = (zone < PageCount) ? zone : PageCount;
      r = '0;
      if (op == 1'b0) begin
        if (ord >= OrderCount) r.status = StNoBlk;
        else if (!mark_clear(ord)) r.status = StWmark;
        else begin
          k = ord;
          while (k < OrderCount && first_blk[k] >= PageCount) k++;
          if (k >= OrderCount) r.status = StNoBlk;
          else begin
            p = first_blk[k];
            sz = 1 << ord;
            drop_head(p);
            total = (total >= sz) ? total - sz : 0;
            while (k > ord) begin
              k--;
              if (p + (1 << k) < PageCount) add_head(p + (1 << k), k);
            end
            r.status = StOk;
            r.page = 10'(p);
            r.order = 4'(ord);
          end
        end
      end else begin
        sz = (ord < OrderCount) ? (1 << ord) : 0;
        if (ord >= OrderCount || (page & (sz - 1)) != 0 || page >= lim ||
            sz > lim - page || head_flag[page]) begin
          r.status = StBadFree;
        end else begin
          total = (total + sz > TotalMax) ? TotalMax : total + sz;
          while (ord < OrderCount - 1) begin
            p = page ^ (1 << ord);
            if (p >= lim) break;
            if (!head_flag[p] || head_ord[p] != ord) break;
            drop_head(p);
            page = page & ~(1 << ord);
            ord++;
          end
          add_head(page, ord);
          r.status = StOk;
          r.page = 10'(page);
          r.order = 4'(ord);
        end
      end
      r.free_now = 11'(total);
      pending_q.push_back(r);
      return r;
    endfunction

    function void check_result(logic [31:0] data);
      alloc_result_t got, exp;
      got.status = data[1:0];
      got.page = data[11:2];
      got.order = data[15:12];
      got.free_now = data[26:16];
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, data);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.status != exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.page != exp.page) begin
        $display("%0t: result_page expected %0d actual %0d", $time, exp.page, got.page);
        errors++;
      end
      if (got.order != exp.order) begin
        $display("%0t: result_order expected %0d actual %0d", $time, exp.order, got.order);
        errors++;
      end
      if (got.free_now != exp.free_now) begin
        $display("%0t: free_pages_now expected %0d actual %0d", $time, exp.free_now,
                 got.free_now);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [0] operation, [4:1] block_order, [14:5] page_index
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [1:0] status, [11:2] page, [15:12] order, [26:16] free
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  buddy_page_allocator u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  buddy_scoreboard sb = new();
  bit          calm = 0;        // no idling on either side
  bit          hold_req = 0;    // ask the receiver for a long hold-off
  int unsigned cycle_cnt = 0;
  logic [13:0] owned_q[$];      // {order, page} of blocks handed out

  // Give up at a generous cycle limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 1000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: sample the handshake at the falling edge, act on the rising edge.
  initial begin
    bit fire;
    logic [31:0] data;
    int unsigned hold;
    forever begin
      @(negedge clk_i);
      fire = m_axis_tvalid && m_axis_tready;
      data = m_axis_tdata;
      @(posedge clk_i);
      if (fire) sb.check_result(data);
      if (hold_req) begin
        // Stall the output long enough for the input side to back up.
        m_axis_tready <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(posedge clk_i);
        hold_req = 0;
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 29);
    end
  end

  task automatic reg_write(logic [1:0] idx, int unsigned val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(logic op, logic [3:0] ord, logic [9:0] pg);
    alloc_result_t r;
    bit taken;
    if (!calm && $urandom_range(99) < 29) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, pg, ord, op};
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    r = sb.note_request(op, ord, pg);
    if (op == 1'b0 && r.status == StOk) owned_q.push_back({r.order, r.page});
  endtask

  // Hold until every result is back, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_item();
    int unsigned r, idx, ord;
    logic [13:0] blk;
    r = $urandom_range(99);
    if (r < 35) begin
      ord = ($urandom_range(9) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 3);
      send_item(1'b0, 4'(ord), 10'($urandom));
    end else if (r < 70 && owned_q.size() != 0) begin
      // Return a block handed out earlier.
      idx = $urandom_range(owned_q.size() - 1);
      blk = owned_q[idx];
      owned_q.delete(idx);
      send_item(1'b1, blk[13:10], blk[9:0]);
    end else if (r < 88) begin
      ord = ($urandom_range(4) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 4);
      send_item(1'b1, 4'(ord), 10'($urandom) & ~10'((1 << ord) - 1));
    end else begin
      send_item(1'($urandom), 4'($urandom), 10'($urandom));
    end
  endtask

  task automatic random_phase(int unsigned count, int unsigned zone, int unsigned lowm,
                              int unsigned resv);
    reg_write(RegZone, zone);
    reg_write(RegLowMark, lowm);
    reg_write(RegReserve, resv);
    for (int i = 0; i < count; i++) random_item();
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reg_write(RegZone, 1024);
    reg_write(RegLowMark, 0);
    reg_write(RegReserve, 0);

    // Directed: whole zone, splits, order limits, bad and overlapping frees.
    send_item(1'b1, 4'd10, 10'd0);
    send_item(1'b0, 4'd0, 10'd0);
    send_item(1'b0, 4'd10, 10'd0);
    send_item(1'b0, 4'd11, 10'd0);
    send_item(1'b0, 4'd15, 10'h3FF);
    send_item(1'b1, 4'd11, 10'd0);
    send_item(1'b1, 4'd15, 10'h3FF);
    send_item(1'b1, 4'd2, 10'd3);
    send_item(1'b1, 4'd9, 10'd512);
    send_item(1'b1, 4'd3, 10'd520);
    send_item(1'b0, 4'd3, 10'd0);
    send_item(1'b1, 4'd0, 10'd1023);
    send_item(1'b1, 4'd0, 10'd0);
    send_item(1'b1, 4'd4, 10'd1016);
    send_item(1'b0, 4'd1, 10'd0);
    send_item(1'b0, 4'd2, 10'd0);
    send_item(1'b0, 4'd9, 10'd0);
    send_item(1'b1, 4'd10, 10'd0);
    drain();

    // Hold off the receiver while the sender keeps offering.
    reg_write(RegZone, 1024);
    hold_req = 1;
    for (int i = 0; i < 80; i++) random_item();
    drain();
    for (int i = 0; i < 100; i++) random_item();
    drain();

    random_phase(170, 1024, 16, 8);
    random_phase(170, 512, 0, 0);
    random_phase(60, 0, 0, 0);
    random_phase(60, 1024, 1024, 1024);
    random_phase(150, 700, 40, 1024);
    calm = 1;
    random_phase(170, 1024, 0, 0);
    calm = 0;
    random_phase(80, 1024, 3, 0);

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
